// ===== rtl/core/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, constants and the divider step for the pressure and
// temperature compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int RAW_W  = 20;
    localparam int CAL_W  = 48;
    localparam int NUM_W  = 61;     // magnitude of the pressure numerator
    localparam int DEN_W  = 36;     // magnitude of the pressure divisor
    localparam int QUOT_W = 41;     // integer quotient bits
    localparam int FRAC_W = 12;     // bits of the scaled fraction quotient
    localparam int FNUM_W = DEN_W + FRAC_W;
    localparam int QM_W   = QUOT_W + FRAC_W;
    localparam int RES_W  = 41;

    localparam logic [1:0] CFG_TEMP    = 2'd0;
    localparam logic [1:0] CFG_PRESS_A = 2'd1;
    localparam logic [1:0] CFG_PRESS_B = 2'd2;
    localparam logic [1:0] CFG_PRESS_C = 2'd3;

    localparam logic [FRAC_W-1:0] SCALE_3125 = 12'd3125;

    localparam logic signed [19:0] TC_LIMIT   = 20'sd10000;
    localparam logic signed [19:0] TC_SAT_HI  = 20'sd32767;
    localparam logic signed [19:0] TC_SAT_LO  = -20'sd32768;
    localparam logic signed [24:0] TF_OFFSET  = 25'sd128000;
    localparam logic signed [51:0] AA_BIAS    = 52'sh0_8000_0000_0000;

    localparam logic [QM_W:0]         M_POS_LIM = 54'h00_00FF_FFFF_FFFF;
    localparam logic [QM_W:0]         M_NEG_LIM = 54'h00_0100_0000_0000;
    localparam logic signed [RES_W-1:0] Q_MAX   = 41'sh0FF_FFFF_FFFF;
    localparam logic signed [RES_W-1:0] Q_MIN   = 41'sh100_0000_0000;

    localparam logic signed [RES_W-1:0] P_LOW     = 41'sd20480000;
    localparam logic signed [RES_W-1:0] P_HIGH    = 41'sd30720000;
    localparam logic signed [RES_W-1:0] PRESS_MAX = 41'sd4294967295;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TEMP  = 2'd1,
        ST_PRESS = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } cal_t;

    // side information that rides along with each beat
    typedef struct packed {
        logic signed [15:0] temp;
        logic               tfail;
        logic               dz;
        logic               ovf;
        logic               neg;
    } tag_t;

    // one restoring step: returns {quotient bit, next partial remainder}
    function automatic logic [DEN_W:0] div_step(
        input logic [DEN_W-1:0] pr,
        input logic             bit_in,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0] t;
        logic [DEN_W:0] diff;
        t    = {pr, bit_in};
        diff = t - {1'b0, den};
        if (t >= {1'b0, den})
        begin
            return {1'b1, diff[DEN_W-1:0]};
        end
        return {1'b0, t[DEN_W-1:0]};
    endfunction

endpackage

// ===== rtl/core/ptc_front.sv =====
// ----------------------------------------------------------------------------
// ptc_front
// Temperature path, fine temperature and the pressure numerator and
// divisor, ten register stages.
// ----------------------------------------------------------------------------
module ptc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ptc_pkg::RAW_W-1:0]   raw_pressure,
    input  logic [ptc_pkg::RAW_W-1:0]   raw_temperature,
    input  ptc_pkg::cal_t               cal,
    output logic                        out_valid,
    output logic [ptc_pkg::NUM_W-1:0]   out_num,
    output logic [ptc_pkg::DEN_W-1:0]   out_den,
    output ptc_pkg::tag_t               out_tag
);
    import ptc_pkg::*;

    logic [9:0] vld_reg;

    logic signed [33:0] s1_pa_reg;
    logic [31:0]        s1_dd_reg;
    logic signed [22:0] s2_a_reg;
    logic signed [36:0] s2_bp_reg;
    logic signed [23:0] s3_tf_reg;
    logic signed [19:0] s4_tc_reg;
    logic signed [21:0] s4_v1_reg;
    logic signed [41:0] s5_vv_reg;
    logic signed [37:0] s5_vp5_reg;
    logic signed [37:0] s5_vp2_reg;
    logic signed [57:0] s6_vvp6_reg;
    logic signed [57:0] s6_vvp3_reg;
    logic signed [37:0] s6_vp5_reg;
    logic signed [37:0] s6_vp2_reg;
    logic signed [59:0] s7_v2_reg;
    logic signed [51:0] s7_aa_reg;
    logic signed [51:0] s8_ph_reg;
    logic [32:0]        s8_pl_reg;
    logic signed [61:0] s8_num_reg;
    logic signed [35:0] s9_div_reg;
    logic signed [61:0] s9_num_reg;
    logic [NUM_W-1:0]   s10_num_reg;
    logic [DEN_W-1:0]   s10_den_reg;

    logic [RAW_W-1:0] p_reg [7];
    tag_t             tag_reg [6];

    logic signed [17:0] x_w;
    logic signed [16:0] d_w;
    logic signed [33:0] pa_w;
    logic signed [33:0] dd_w;
    logic signed [33:0] ash_w;
    logic signed [36:0] bp_w;
    logic signed [36:0] bsh_w;
    logic signed [23:0] tf_w;
    logic signed [27:0] t5_w;
    logic signed [27:0] tsh_w;
    logic signed [24:0] v1_w;
    logic signed [41:0] vv_w;
    logic signed [37:0] vp5_w;
    logic signed [37:0] vp2_w;
    tag_t               tag5_w;
    logic signed [57:0] vvp6_w;
    logic signed [57:0] vvp3_w;
    logic signed [59:0] v2_w;
    logic signed [51:0] aa_w;
    logic signed [51:0] ph_w;
    logic [32:0]        pl_w;
    logic [20:0]        pr_w;
    logic signed [61:0] num_w;
    logic signed [52:0] dsum_w;
    logic signed [52:0] dsh_w;
    logic signed [61:0] nneg_w;
    logic signed [35:0] dneg_w;
    tag_t               tag10_w;

    // temperature
    assign x_w   = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
    assign d_w   = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
    assign pa_w  = x_w * $signed(cal.t2);
    assign dd_w  = d_w * d_w;
    assign ash_w = s1_pa_reg >>> 11;
    assign bp_w  = $signed({1'b0, s1_dd_reg[31:12]}) * $signed(cal.t3);
    assign bsh_w = s2_bp_reg >>> 14;
    assign tf_w  = s2_a_reg + $signed(bsh_w[22:0]);
    assign t5_w  = s3_tf_reg * 28'sd5 + 28'sd128;
    assign tsh_w = t5_w >>> 8;
    assign v1_w  = s3_tf_reg - TF_OFFSET;

    // pressure polynomial terms
    assign vv_w  = s4_v1_reg * s4_v1_reg;
    assign vp5_w = s4_v1_reg * $signed(cal.p5);
    assign vp2_w = s4_v1_reg * $signed(cal.p2);

    always_comb
    begin
        tag5_w       = '0;
        tag5_w.tfail = (s4_tc_reg > TC_LIMIT) || (s4_tc_reg < -TC_LIMIT);
        if (s4_tc_reg > TC_SAT_HI)
        begin
            tag5_w.temp = 16'sh7FFF;
        end
        else if (s4_tc_reg < TC_SAT_LO)
        begin
            tag5_w.temp = 16'sh8000;
        end
        else
        begin
            tag5_w.temp = s4_tc_reg[15:0];
        end
    end

    assign vvp6_w = s5_vv_reg * $signed(cal.p6);
    assign vvp3_w = s5_vv_reg * $signed(cal.p3);
    assign v2_w   = 60'(s6_vvp6_reg) + (60'(s6_vp5_reg) <<< 17)
                  + (60'($signed(cal.p4)) <<< 35);
    assign aa_w   = 52'(s6_vvp3_reg >>> 8) + (52'(s6_vp2_reg) <<< 12) + AA_BIAS;

    // divisor = (aa * p1) >> 33, split around bit 17
    assign ph_w   = $signed(s7_aa_reg[51:17]) * $signed({1'b0, cal.p1});
    assign pl_w   = s7_aa_reg[16:0] * cal.p1;
    assign pr_w   = 21'd1048576 - {1'b0, p_reg[6]};
    assign num_w  = $signed({10'd0, pr_w, 31'd0}) - 62'(s7_v2_reg);
    assign dsum_w = 53'(s8_ph_reg) + $signed({37'd0, s8_pl_reg[32:17]});
    assign dsh_w  = dsum_w >>> 16;

    assign nneg_w = -s9_num_reg;
    assign dneg_w = -s9_div_reg;

    always_comb
    begin
        tag10_w     = tag_reg[4];
        tag10_w.dz  = (s9_div_reg == '0);
        tag10_w.neg = s9_num_reg[61] ^ s9_div_reg[35];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[8:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pa_reg   <= pa_w;
            s1_dd_reg   <= dd_w[31:0];
            s2_a_reg    <= ash_w[22:0];
            s2_bp_reg   <= bp_w;
            s3_tf_reg   <= tf_w;
            s4_tc_reg   <= tsh_w[19:0];
            s4_v1_reg   <= v1_w[21:0];
            s5_vv_reg   <= vv_w;
            s5_vp5_reg  <= vp5_w;
            s5_vp2_reg  <= vp2_w;
            s6_vvp6_reg <= vvp6_w;
            s6_vvp3_reg <= vvp3_w;
            s6_vp5_reg  <= s5_vp5_reg;
            s6_vp2_reg  <= s5_vp2_reg;
            s7_v2_reg   <= v2_w;
            s7_aa_reg   <= aa_w;
            s8_ph_reg   <= ph_w;
            s8_pl_reg   <= pl_w;
            s8_num_reg  <= num_w;
            s9_div_reg  <= dsh_w[35:0];
            s9_num_reg  <= s8_num_reg;
            s10_num_reg <= s9_num_reg[61] ? nneg_w[NUM_W-1:0] : s9_num_reg[NUM_W-1:0];
            s10_den_reg <= s9_div_reg[35] ? dneg_w : s9_div_reg;
            p_reg[0]    <= raw_pressure;
            for (int k = 1; k < 7; k++)
            begin
                p_reg[k] <= p_reg[k-1];
            end
            tag_reg[0] <= tag5_w;
            for (int k = 1; k < 5; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
            tag_reg[5] <= tag10_w;
        end
    end

    assign out_valid = vld_reg[9];
    assign out_num   = s10_num_reg;
    assign out_den   = s10_den_reg;
    assign out_tag   = tag_reg[5];

endmodule

// ===== rtl/core/ptc_quot.sv =====
// ----------------------------------------------------------------------------
// ptc_quot
// Unsigned restoring divider for the integer quotient, one bit per stage,
// with an up-front check for a quotient too wide to represent.
// ----------------------------------------------------------------------------
module ptc_quot (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ptc_pkg::NUM_W-1:0]   in_num,
    input  logic [ptc_pkg::DEN_W-1:0]   in_den,
    input  ptc_pkg::tag_t               in_tag,
    output logic                        out_valid,
    output logic [ptc_pkg::QUOT_W-1:0]  out_quot,
    output logic [ptc_pkg::DEN_W-1:0]   out_rem,
    output logic [ptc_pkg::DEN_W-1:0]   out_den,
    output ptc_pkg::tag_t               out_tag
);
    import ptc_pkg::*;

    localparam int STEPS = QUOT_W;

    logic [STEPS:0]    vld_reg;
    logic [DEN_W-1:0]  pr_reg  [STEPS+1];
    logic [QUOT_W-1:0] lo_reg  [STEPS+1];
    logic [DEN_W-1:0]  den_reg [STEPS+1];
    tag_t              tag_reg [STEPS+1];

    logic [DEN_W:0]    step_w  [STEPS];
    tag_t              tag0_w;

    always_comb
    begin
        tag0_w     = in_tag;
        tag0_w.ovf = DEN_W'(in_num[NUM_W-1:QUOT_W]) >= in_den;
    end

    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            step_w[k] = div_step(pr_reg[k], lo_reg[k][QUOT_W-1], den_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg[0]  <= DEN_W'(in_num[NUM_W-1:QUOT_W]);
            lo_reg[0]  <= in_num[QUOT_W-1:0];
            den_reg[0] <= in_den;
            tag_reg[0] <= tag0_w;
            for (int k = 0; k < STEPS; k++)
            begin
                pr_reg[k+1]  <= step_w[k][DEN_W-1:0];
                lo_reg[k+1]  <= {lo_reg[k][QUOT_W-2:0], step_w[k][DEN_W]};
                den_reg[k+1] <= den_reg[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[STEPS];
    assign out_quot  = lo_reg[STEPS];
    assign out_rem   = pr_reg[STEPS];
    assign out_den   = den_reg[STEPS];
    assign out_tag   = tag_reg[STEPS];

endmodule

// ===== rtl/core/ptc_frac.sv =====
// ----------------------------------------------------------------------------
// ptc_frac
// Scales quotient and remainder by 3125 and divides the scaled remainder
// once more, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ptc_frac (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ptc_pkg::QUOT_W-1:0]  in_quot,
    input  logic [ptc_pkg::DEN_W-1:0]   in_rem,
    input  logic [ptc_pkg::DEN_W-1:0]   in_den,
    input  ptc_pkg::tag_t               in_tag,
    output logic                        out_valid,
    output logic [ptc_pkg::QM_W-1:0]    out_qm,
    output logic [ptc_pkg::FRAC_W-1:0]  out_fq,
    output ptc_pkg::tag_t               out_tag
);
    import ptc_pkg::*;

    localparam int STEPS = FRAC_W;

    logic [STEPS:0]    vld_reg;
    logic [DEN_W-1:0]  pr_reg  [STEPS+1];
    logic [FRAC_W-1:0] lo_reg  [STEPS+1];
    logic [DEN_W-1:0]  den_reg [STEPS+1];
    logic [QM_W-1:0]   qm_reg  [STEPS+1];
    tag_t              tag_reg [STEPS+1];

    logic [FNUM_W-1:0] fn_w;
    logic [QM_W-1:0]   qm_w;
    logic [DEN_W:0]    step_w [STEPS];

    assign fn_w = in_rem * SCALE_3125;
    assign qm_w = in_quot * SCALE_3125;

    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            step_w[k] = div_step(pr_reg[k], lo_reg[k][FRAC_W-1], den_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STEPS-1:0], in_valid};
        end
    end

    // rem < den, so the scaled high part always starts below the divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg[0]  <= fn_w[FNUM_W-1:FRAC_W];
            lo_reg[0]  <= fn_w[FRAC_W-1:0];
            den_reg[0] <= in_den;
            qm_reg[0]  <= qm_w;
            tag_reg[0] <= in_tag;
            for (int k = 0; k < STEPS; k++)
            begin
                pr_reg[k+1]  <= step_w[k][DEN_W-1:0];
                lo_reg[k+1]  <= {lo_reg[k][FRAC_W-2:0], step_w[k][DEN_W]};
                den_reg[k+1] <= den_reg[k];
                qm_reg[k+1]  <= qm_reg[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[STEPS];
    assign out_qm    = qm_reg[STEPS];
    assign out_fq    = lo_reg[STEPS];
    assign out_tag   = tag_reg[STEPS];

endmodule

// ===== rtl/core/ptc_back.sv =====
// ----------------------------------------------------------------------------
// ptc_back
// Signed, saturated quotient and the second-order pressure terms,
// six register stages.
// ----------------------------------------------------------------------------
module ptc_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [ptc_pkg::QM_W-1:0]          in_qm,
    input  logic [ptc_pkg::FRAC_W-1:0]        in_fq,
    input  ptc_pkg::tag_t                     in_tag,
    input  ptc_pkg::cal_t                     cal,
    output logic                              out_valid,
    output logic signed [ptc_pkg::RES_W-1:0]  out_res,
    output ptc_pkg::tag_t                     out_tag
);
    import ptc_pkg::*;

    logic [5:0] vld_reg;
    tag_t       tag_reg [6];

    logic [QM_W:0]             b1_m_reg;
    logic signed [RES_W-1:0]   b2_q_reg;
    logic signed [RES_W-1:0]   b3_q_reg;
    logic [54:0]               b3_sq_reg;
    logic signed [56:0]        b3_p8q_reg;
    logic signed [RES_W-1:0]   b4_q_reg;
    logic signed [45:0]        b4_t1_reg;
    logic signed [41:0]        b4_t2_reg;
    logic signed [37:0]        b4_v2_reg;
    logic signed [47:0]        b5_sum_reg;
    logic signed [RES_W-1:0]   b6_res_reg;

    logic [QM_W:0]             m_w;
    logic signed [RES_W-1:0]   q_w;
    logic signed [RES_W-1:0]   ash_w;
    logic signed [55:0]        sq_w;
    logic signed [56:0]        p8q_w;
    logic signed [45:0]        t1_w;
    logic signed [41:0]        t2_w;
    logic signed [56:0]        v2sh_w;
    logic signed [41:0]        t2sh_w;
    logic signed [47:0]        sum_w;
    logic signed [47:0]        ssh_w;
    logic signed [RES_W-1:0]   res_w;

    assign m_w = (QM_W+1)'(in_qm) + (QM_W+1)'(in_fq);

    always_comb
    begin
        if (tag_reg[0].ovf)
        begin
            q_w = tag_reg[0].neg ? Q_MIN : Q_MAX;
        end
        else if (!tag_reg[0].neg)
        begin
            q_w = (b1_m_reg > M_POS_LIM) ? Q_MAX : $signed(b1_m_reg[RES_W-1:0]);
        end
        else
        begin
            q_w = (b1_m_reg > M_NEG_LIM) ? Q_MIN : -$signed(b1_m_reg[RES_W-1:0]);
        end
    end

    assign ash_w  = b2_q_reg >>> 13;
    assign sq_w   = $signed(ash_w[27:0]) * $signed(ash_w[27:0]);
    assign p8q_w  = b2_q_reg * $signed(cal.p8);
    assign t1_w   = $signed(cal.p9) * $signed({1'b0, b3_sq_reg[54:25]});
    assign t2_w   = $signed(cal.p9) * $signed({1'b0, b3_sq_reg[24:0]});
    assign v2sh_w = b3_p8q_reg >>> 19;
    assign t2sh_w = b4_t2_reg >>> 25;
    assign sum_w  = 48'(b4_q_reg) + 48'(b4_t1_reg) + 48'(t2sh_w) + 48'(b4_v2_reg);
    assign ssh_w  = b5_sum_reg >>> 8;
    assign res_w  = RES_W'(ssh_w) + (RES_W'($signed(cal.p7)) <<< 4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_m_reg   <= m_w;
            b2_q_reg   <= q_w;
            b3_q_reg   <= b2_q_reg;
            b3_sq_reg  <= sq_w[54:0];
            b3_p8q_reg <= p8q_w;
            b4_q_reg   <= b3_q_reg;
            b4_t1_reg  <= t1_w;
            b4_t2_reg  <= t2_w;
            b4_v2_reg  <= v2sh_w[37:0];
            b5_sum_reg <= sum_w;
            b6_res_reg <= res_w;
            tag_reg[0] <= in_tag;
            for (int k = 1; k < 6; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[5];
    assign out_res   = b6_res_reg;
    assign out_tag   = tag_reg[5];

endmodule

// ===== rtl/core/pressure_temperature_compensation.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Fixed-point barometric compensation of one raw pressure and temperature
// pair into centi-degrees and pascal in Q24.8, with range status.
//
//   channel   signals                                   direction
//   sample    sample_valid, sample_stall, raw_*         into the block
//   result    result_valid, result_stall, outputs       out of the block
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data into the block
//
// one beat is taken every cycle while no stalled result freezes the pipeline;
// the bit-per-stage dividers (41 and 12 stages) sit between the arithmetic stages
// reset clears all valid bits and the four calibration registers
// a stalled result freezes the whole pipeline, so nothing is lost or repeated
// cfg_ready is always high; writes belong to idle periods
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [ptc_pkg::RAW_W-1:0]     raw_pressure,
    input  logic [ptc_pkg::RAW_W-1:0]     raw_temperature,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [15:0]            temperature_centi,
    output logic [31:0]                   pressure_q24_8,
    output logic [1:0]                    status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [ptc_pkg::CAL_W-1:0]     cfg_data
);
    import ptc_pkg::*;

    logic [CAL_W-1:0] cal_temp_reg;
    logic [CAL_W-1:0] cal_press_a_reg;
    logic [CAL_W-1:0] cal_press_b_reg;
    logic [CAL_W-1:0] cal_press_c_reg;

    logic               result_valid_reg;
    logic signed [15:0] temp_reg;
    logic [31:0]        press_reg;
    status_t            status_reg;

    logic en;
    cal_t cal;

    logic              fr_valid;
    logic [NUM_W-1:0]  fr_num;
    logic [DEN_W-1:0]  fr_den;
    tag_t              fr_tag;
    logic              qu_valid;
    logic [QUOT_W-1:0] qu_quot;
    logic [DEN_W-1:0]  qu_rem;
    logic [DEN_W-1:0]  qu_den;
    tag_t              qu_tag;
    logic              fc_valid;
    logic [QM_W-1:0]   fc_qm;
    logic [FRAC_W-1:0] fc_fq;
    tag_t              fc_tag;
    logic              bk_valid;
    logic signed [RES_W-1:0] bk_res;
    tag_t              bk_tag;

    logic [31:0] press_next;
    status_t     status_next;

    assign en           = !result_valid_reg || !result_stall;
    assign sample_stall = !en;
    assign cfg_ready    = 1'b1;

    assign cal.t1 = cal_temp_reg[15:0];
    assign cal.t2 = cal_temp_reg[31:16];
    assign cal.t3 = cal_temp_reg[47:32];
    assign cal.p1 = cal_press_a_reg[15:0];
    assign cal.p2 = cal_press_a_reg[31:16];
    assign cal.p3 = cal_press_a_reg[47:32];
    assign cal.p4 = cal_press_b_reg[15:0];
    assign cal.p5 = cal_press_b_reg[31:16];
    assign cal.p6 = cal_press_b_reg[47:32];
    assign cal.p7 = cal_press_c_reg[15:0];
    assign cal.p8 = cal_press_c_reg[31:16];
    assign cal.p9 = cal_press_c_reg[47:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_temp_reg    <= '0;
            cal_press_a_reg <= '0;
            cal_press_b_reg <= '0;
            cal_press_c_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TEMP:    cal_temp_reg    <= cfg_data;
                CFG_PRESS_A: cal_press_a_reg <= cfg_data;
                CFG_PRESS_B: cal_press_b_reg <= cfg_data;
                CFG_PRESS_C: cal_press_c_reg <= cfg_data;
                default:     cal_temp_reg    <= cal_temp_reg;
            endcase
        end
    end

    ptc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (sample_valid),
        .raw_pressure    (raw_pressure),
        .raw_temperature (raw_temperature),
        .cal             (cal),
        .out_valid       (fr_valid),
        .out_num         (fr_num),
        .out_den         (fr_den),
        .out_tag         (fr_tag)
    );

    ptc_quot u_quot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_num    (fr_num),
        .in_den    (fr_den),
        .in_tag    (fr_tag),
        .out_valid (qu_valid),
        .out_quot  (qu_quot),
        .out_rem   (qu_rem),
        .out_den   (qu_den),
        .out_tag   (qu_tag)
    );

    ptc_frac u_frac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (qu_valid),
        .in_quot   (qu_quot),
        .in_rem    (qu_rem),
        .in_den    (qu_den),
        .in_tag    (qu_tag),
        .out_valid (fc_valid),
        .out_qm    (fc_qm),
        .out_fq    (fc_fq),
        .out_tag   (fc_tag)
    );

    ptc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fc_valid),
        .in_qm     (fc_qm),
        .in_fq     (fc_fq),
        .in_tag    (fc_tag),
        .cal       (cal),
        .out_valid (bk_valid),
        .out_res   (bk_res),
        .out_tag   (bk_tag)
    );

    // temperature failure wins over a zero divisor
    always_comb
    begin
        if (bk_tag.tfail)
        begin
            status_next = ST_TEMP;
        end
        else if (bk_tag.dz)
        begin
            status_next = ST_DIVZ;
        end
        else if ((bk_res < P_LOW) || (bk_res > P_HIGH))
        begin
            status_next = ST_PRESS;
        end
        else
        begin
            status_next = ST_OK;
        end

        if (bk_tag.tfail || bk_tag.dz || (bk_res < 0))
        begin
            press_next = '0;
        end
        else if (bk_res > PRESS_MAX)
        begin
            press_next = 32'hFFFF_FFFF;
        end
        else
        begin
            press_next = bk_res[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            result_valid_reg <= bk_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp_reg   <= bk_tag.temp;
            press_reg  <= press_next;
            status_reg <= status_next;
        end
    end

    assign result_valid      = result_valid_reg;
    assign temperature_centi = temp_reg;
    assign pressure_q24_8    = press_reg;
    assign status            = status_reg;

endmodule
